// ===== design/sbds_pkg.sv =====
// Shared types, codes and constants for the sparse block detail store.
package sbds_pkg;

    localparam int DEF_MAX_VERTICES = 4096;
    localparam int DEF_MAX_BLOCKS   = 1024;

    localparam int VERTEX_W = 12;
    localparam int VTOTAL_W = 13;
    localparam int SHIFT_W  = 4;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 11;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 4'd2;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 4'd12;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd6;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_VERTEX_TOTAL = 1'b0;
    localparam logic REG_BLOCK_SHIFT  = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [VERTEX_W-1:0] vertex;
        logic [WORD_W-1:0] tangent_bits;
        logic [WORD_W-1:0] bitangent_bits;
        logic [WORD_W-1:0] normal_bits;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0]  read_tangent;
        logic [WORD_W-1:0]  read_bitangent;
        logic [WORD_W-1:0]  read_normal;
        logic               in_range;
        logic               block_present;
        logic               write_dropped;
        logic               dense_mode;
        logic [COUNT_W-1:0] stored_blocks;
    } out_item_t;

    typedef struct packed {
        logic [SHIFT_W-1:0]  eff_shift;
        logic [VTOTAL_W-1:0] eff_total;
        logic [VTOTAL_W-1:0] blk_count;
        logic                clear_busy;
        logic                clear_start;
    } cfg_t;

endpackage

// ===== design/sbds_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
module sbds_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/sbds_cfg.sv =====
// Configuration registers, effective geometry and the table clearing sweep.
module sbds_cfg #(
    parameter int  MAX_VERTICES = sbds_pkg::DEF_MAX_VERTICES,
    parameter int  MAX_BLOCKS   = sbds_pkg::DEF_MAX_BLOCKS,
    localparam int CLR_DEPTH    = (MAX_VERTICES > MAX_BLOCKS) ? MAX_VERTICES : MAX_BLOCKS,
    localparam int CLR_W        = $clog2(CLR_DEPTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbds_pkg::PADDR_W-1:0]  paddr,
    input  logic [sbds_pkg::PDATA_W-1:0]  pwdata,
    output logic [sbds_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output sbds_pkg::cfg_t                cfg,
    output logic [CLR_W-1:0]              clr_addr
);

    import sbds_pkg::*;

    logic [VTOTAL_W-1:0] vtotal_reg;
    logic [SHIFT_W-1:0]  shift_reg;
    logic [SHIFT_W-1:0]  eff_shift_reg, eff_shift_next;
    logic [VTOTAL_W-1:0] eff_total_reg, eff_total_next;
    logic [VTOTAL_W-1:0] blk_count_reg, blk_count_next;
    logic                clr_busy_reg, clr_busy_next;
    logic [CLR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic                wr_fire;
    logic                reg_sel;
    logic [31:0]         cap;
    logic [31:0]         tot_a;
    logic [31:0]         tot_b;
    logic [31:0]         mask;

    assign wr_fire = psel & penable & pwrite;
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtotal_reg <= '0;
            shift_reg  <= SHIFT_RESET;
        end
        else if (wr_fire)
        begin
            case (reg_sel)
                REG_VERTEX_TOTAL: vtotal_reg <= pwdata[VTOTAL_W-1:0];
                REG_BLOCK_SHIFT:  shift_reg  <= pwdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_VERTEX_TOTAL: prdata = PDATA_W'(vtotal_reg);
            REG_BLOCK_SHIFT:  prdata = PDATA_W'(shift_reg);
            default:          prdata = '0;
        endcase
    end

    // clamp shift, cap total by storage and by block count, round up to blocks
    always_comb
    begin
        if (shift_reg < SHIFT_MIN)
        begin
            eff_shift_next = SHIFT_MIN;
        end
        else if (shift_reg > SHIFT_MAX)
        begin
            eff_shift_next = SHIFT_MAX;
        end
        else
        begin
            eff_shift_next = shift_reg;
        end
        cap   = 32'(MAX_BLOCKS) << eff_shift_next;
        tot_a = (32'(vtotal_reg) > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES) : 32'(vtotal_reg);
        tot_b = (tot_a > cap) ? cap : tot_a;
        mask  = (32'd1 << eff_shift_next) - 32'd1;
        eff_total_next = VTOTAL_W'(tot_b);
        blk_count_next = VTOTAL_W'((tot_b + mask) >> eff_shift_next);
    end

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (wr_fire)
        begin
            clr_busy_next = 1'b1;
            clr_cnt_next  = '0;
        end
        else if (clr_busy_reg)
        begin
            if (32'(clr_cnt_reg) == 32'(CLR_DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_shift_reg <= SHIFT_RESET;
            eff_total_reg <= '0;
            blk_count_reg <= '0;
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            eff_shift_reg <= eff_shift_next;
            eff_total_reg <= eff_total_next;
            blk_count_reg <= blk_count_next;
            clr_busy_reg  <= clr_busy_next;
            clr_cnt_reg   <= clr_cnt_next;
        end
    end

    always_comb
    begin
        cfg.eff_shift   = eff_shift_reg;
        cfg.eff_total   = eff_total_reg;
        cfg.blk_count   = blk_count_reg;
        cfg.clear_busy  = clr_busy_reg;
        cfg.clear_start = wr_fire;
    end

    assign clr_addr = clr_cnt_reg;

endmodule

// ===== design/sbds_ctrl.sv =====
// Request sequencer: map lookup, slot allocation, data access, result register.
module sbds_ctrl #(
    parameter int  MAX_VERTICES = sbds_pkg::DEF_MAX_VERTICES,
    parameter int  MAX_BLOCKS   = sbds_pkg::DEF_MAX_BLOCKS,
    localparam int CLR_DEPTH    = (MAX_VERTICES > MAX_BLOCKS) ? MAX_VERTICES : MAX_BLOCKS,
    localparam int CLR_W        = $clog2(CLR_DEPTH),
    localparam int BA_W         = $clog2(MAX_BLOCKS),
    localparam int VA_W         = $clog2(MAX_VERTICES),
    localparam int MAP_W        = BA_W + 1,
    localparam int ST_W         = 3 * sbds_pkg::WORD_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sbds_pkg::cfg_t       cfg,
    input  logic [CLR_W-1:0]     clr_addr,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  sbds_pkg::in_item_t   req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output sbds_pkg::out_item_t  rsp_data,
    output logic                 map_rd_en,
    output logic [BA_W-1:0]      map_rd_addr,
    input  logic [MAP_W-1:0]     map_rd_data,
    output logic                 map_wr_en,
    output logic [BA_W-1:0]      map_wr_addr,
    output logic [MAP_W-1:0]     map_wr_data,
    output logic                 st_rd_en,
    output logic [VA_W-1:0]      st_rd_addr,
    input  logic [ST_W-1:0]      st_rd_data,
    output logic                 st_wr_en,
    output logic [VA_W-1:0]      st_wr_addr,
    output logic [ST_W-1:0]      st_wr_data
);

    import sbds_pkg::*;

    localparam int SC_W = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [1:0] {S_IDLE, S_MAP, S_DATA} state_t;

    state_t              state_reg, state_next;
    in_item_t            item_reg, item_next;
    logic                in_rng_reg, in_rng_next;
    logic                blk_ok_reg, blk_ok_next;
    logic [BA_W-1:0]     blk_reg, blk_next;
    logic [SC_W-1:0]     slot_cnt_reg, slot_cnt_next;
    logic                dense_reg, dense_next;
    logic                rsp_valid_reg, rsp_valid_next;
    out_item_t           rsp_reg, rsp_next;

    logic                accept;
    logic [VERTEX_W-1:0] a_blk;
    logic                a_in_rng;
    logic                a_blk_ok;
    logic [VERTEX_W:0]   mask_w;
    logic [VERTEX_W-1:0] offset;
    logic                m_valid;
    logic [BA_W-1:0]     m_slot;
    logic                is_wr;
    logic                zero_data;
    logic                hit_ok;
    logic                alloc;
    logic                dropped;
    logic [BA_W-1:0]     slot;
    logic [31:0]         idx;
    logic                idx_ok;
    logic                present;
    logic                rd_hit;
    logic                st_write;
    logic [31:0]         cnt_inc;
    logic                can_out;
    logic                fire_map;
    logic                clr_map_ok;
    logic                clr_st_ok;

    assign req_stall = (state_reg != S_IDLE) || cfg.clear_busy || cfg.clear_start;
    assign accept    = req_valid && !req_stall;

    assign a_blk    = req_data.vertex >> cfg.eff_shift;
    assign a_in_rng = {1'b0, req_data.vertex} < cfg.eff_total;
    assign a_blk_ok = 32'(a_blk) < 32'(MAX_BLOCKS);

    assign mask_w = ({{VERTEX_W{1'b0}}, 1'b1} << cfg.eff_shift) - 1'b1;
    assign offset = item_reg.vertex & mask_w[VERTEX_W-1:0];

    assign m_valid   = map_rd_data[BA_W];
    assign m_slot    = map_rd_data[BA_W-1:0];
    assign is_wr     = (item_reg.req_type == REQ_WRITE);
    assign zero_data = (item_reg.tangent_bits == '0) && (item_reg.bitangent_bits == '0)
                       && (item_reg.normal_bits == '0);
    assign hit_ok    = in_rng_reg && blk_ok_reg;
    assign alloc     = is_wr && hit_ok && !m_valid && !zero_data;
    assign dropped   = is_wr && !(hit_ok && (m_valid || !zero_data));
    // a fresh block takes the next slot in order
    assign slot      = m_valid ? m_slot : BA_W'(slot_cnt_reg);
    assign idx       = (32'(slot) << cfg.eff_shift) | 32'(offset);
    assign idx_ok    = idx < 32'(MAX_VERTICES);
    assign present   = hit_ok && (m_valid || alloc);
    assign rd_hit    = !is_wr && hit_ok && m_valid && idx_ok;
    assign st_write  = is_wr && hit_ok && !dropped && idx_ok;
    assign cnt_inc   = 32'(slot_cnt_reg) + 32'd1;

    assign can_out  = !rsp_valid_reg || !rsp_stall;
    assign fire_map = (state_reg == S_MAP) && !rd_hit && can_out;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        in_rng_next    = in_rng_reg;
        blk_ok_next    = blk_ok_reg;
        blk_next       = blk_reg;
        slot_cnt_next  = slot_cnt_reg;
        dense_next     = dense_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next   = req_data;
                    in_rng_next = a_in_rng;
                    blk_ok_next = a_blk_ok;
                    blk_next    = BA_W'(a_blk);
                    state_next  = S_MAP;
                end
            end
            S_MAP:
            begin
                if (rd_hit)
                begin
                    state_next = S_DATA;
                end
                else if (can_out)
                begin
                    state_next = S_IDLE;
                    if (alloc)
                    begin
                        slot_cnt_next = SC_W'(cnt_inc);
                        if (cnt_inc >= 32'(cfg.blk_count))
                        begin
                            dense_next = 1'b1;
                        end
                    end
                    rsp_valid_next          = 1'b1;
                    rsp_next.read_tangent   = '0;
                    rsp_next.read_bitangent = '0;
                    rsp_next.read_normal    = '0;
                    rsp_next.in_range       = in_rng_reg;
                    rsp_next.block_present  = present;
                    rsp_next.write_dropped  = dropped;
                    rsp_next.dense_mode     = dense_next;
                    rsp_next.stored_blocks  = COUNT_W'(slot_cnt_next);
                end
            end
            S_DATA:
            begin
                if (can_out)
                begin
                    state_next              = S_IDLE;
                    rsp_valid_next          = 1'b1;
                    rsp_next.read_tangent   = st_rd_data[3*WORD_W-1:2*WORD_W];
                    rsp_next.read_bitangent = st_rd_data[2*WORD_W-1:WORD_W];
                    rsp_next.read_normal    = st_rd_data[WORD_W-1:0];
                    rsp_next.in_range       = 1'b1;
                    rsp_next.block_present  = 1'b1;
                    rsp_next.write_dropped  = 1'b0;
                    rsp_next.dense_mode     = dense_reg;
                    rsp_next.stored_blocks  = COUNT_W'(slot_cnt_reg);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg.clear_start)
        begin
            slot_cnt_next = '0;
            dense_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            in_rng_reg    <= 1'b0;
            blk_ok_reg    <= 1'b0;
            blk_reg       <= '0;
            slot_cnt_reg  <= '0;
            dense_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            in_rng_reg    <= in_rng_next;
            blk_ok_reg    <= blk_ok_next;
            blk_reg       <= blk_next;
            slot_cnt_reg  <= slot_cnt_next;
            dense_reg     <= dense_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // memory ports; the clearing sweep owns the write ports while it runs
    assign clr_map_ok = 32'(clr_addr) < 32'(MAX_BLOCKS);
    assign clr_st_ok  = 32'(clr_addr) < 32'(MAX_VERTICES);

    assign map_rd_en   = accept;
    assign map_rd_addr = BA_W'(a_blk);
    assign map_wr_en   = cfg.clear_busy ? clr_map_ok : (fire_map && alloc);
    assign map_wr_addr = cfg.clear_busy ? BA_W'(clr_addr) : blk_reg;
    assign map_wr_data = cfg.clear_busy ? '0 : {1'b1, slot};

    assign st_rd_en   = (state_reg == S_MAP) && rd_hit;
    assign st_rd_addr = VA_W'(idx);
    assign st_wr_en   = cfg.clear_busy ? clr_st_ok : (fire_map && st_write);
    assign st_wr_addr = cfg.clear_busy ? VA_W'(clr_addr) : VA_W'(idx);
    assign st_wr_data = cfg.clear_busy ? '0
                        : {item_reg.tangent_bits, item_reg.bitangent_bits, item_reg.normal_bits};

endmodule

// ===== design/sparse_block_detail_store.sv =====
// Sparse block detail store: per-vertex tangent, bitangent and normal words kept in
// blocks that take a storage slot on their first non-zero write. One request is in
// flight at a time: a write, a miss or an out-of-range request is answered after
// the block map read, a read that hits after the block map read and then the data
// memory read, and the next request can be taken once the result is registered.
// The result register lets a request be taken while the previous result still
// waits. After reset and after every register write a clearing sweep over
// max(MAX_VERTICES, MAX_BLOCKS) addresses (4096 by default) zeroes the block map
// and the data memory; requests stall until it completes.
module sparse_block_detail_store #(
    parameter int MAX_VERTICES = sbds_pkg::DEF_MAX_VERTICES,
    parameter int MAX_BLOCKS   = sbds_pkg::DEF_MAX_BLOCKS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbds_pkg::PADDR_W-1:0]  paddr,
    input  logic [sbds_pkg::PDATA_W-1:0]  pwdata,
    output logic [sbds_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  sbds_pkg::in_item_t            req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output sbds_pkg::out_item_t           rsp_data
);

    import sbds_pkg::*;

    localparam int CLR_DEPTH = (MAX_VERTICES > MAX_BLOCKS) ? MAX_VERTICES : MAX_BLOCKS;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam int BA_W      = $clog2(MAX_BLOCKS);
    localparam int VA_W      = $clog2(MAX_VERTICES);
    localparam int MAP_W     = BA_W + 1;
    localparam int ST_W      = 3 * WORD_W;

    cfg_t             cfg;
    logic [CLR_W-1:0] clr_addr;
    logic             map_rd_en;
    logic [BA_W-1:0]  map_rd_addr;
    logic [MAP_W-1:0] map_rd_data;
    logic             map_wr_en;
    logic [BA_W-1:0]  map_wr_addr;
    logic [MAP_W-1:0] map_wr_data;
    logic             st_rd_en;
    logic [VA_W-1:0]  st_rd_addr;
    logic [ST_W-1:0]  st_rd_data;
    logic             st_wr_en;
    logic [VA_W-1:0]  st_wr_addr;
    logic [ST_W-1:0]  st_wr_data;

    sbds_cfg #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_BLOCKS   (MAX_BLOCKS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .clr_addr (clr_addr)
    );

    sbds_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_BLOCKS   (MAX_BLOCKS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .clr_addr    (clr_addr),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data),
        .map_rd_en   (map_rd_en),
        .map_rd_addr (map_rd_addr),
        .map_rd_data (map_rd_data),
        .map_wr_en   (map_wr_en),
        .map_wr_addr (map_wr_addr),
        .map_wr_data (map_wr_data),
        .st_rd_en    (st_rd_en),
        .st_rd_addr  (st_rd_addr),
        .st_rd_data  (st_rd_data),
        .st_wr_en    (st_wr_en),
        .st_wr_addr  (st_wr_addr),
        .st_wr_data  (st_wr_data)
    );

    // block map: valid bit and slot number per block
    sbds_ram #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (MAP_W)
    ) u_map_ram (
        .clk     (clk),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data)
    );

    // slot storage: tangent, bitangent, normal per word
    sbds_ram #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (ST_W)
    ) u_store_ram (
        .clk     (clk),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data)
    );

endmodule

// ===== design/sbds_chk.sv =====
// Port-level assertions for the sparse block detail store, bound to the top level.
module sbds_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic                          req_valid,
    input logic                          req_stall,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input sbds_pkg::out_item_t           rsp_data
);

    // a register write starts a clear: no request may slip in with or right after it
    a_cfg_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite) |-> req_stall ##1 req_stall)
        else $error("request taken around a register write");

    // one request at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("second request taken while one is in flight");

    // a new result only appears for a request already taken
    a_rsp_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result without a pending request");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
        else $error("stalled result changed or dropped");

endmodule

bind sparse_block_detail_store sbds_chk u_sbds_chk (.*);

// ===== tb/sv/sparse_block_detail_store_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sparse_block_detail_store: predicted responses checked per transfer.
module sparse_block_detail_store_tb;
    import sbds_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PCT      = 38;
    localparam int POOL_DEPTH    = 64;
    localparam int LIMIT_NS      = 2000000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                req_valid;
    logic                req_stall;
    in_item_t            req_data;
    logic                rsp_valid;
    logic                rsp_stall;
    out_item_t           rsp_data;

    // predictor state
    logic [VTOTAL_W-1:0] cfg_vertex_total;
    logic [SHIFT_W-1:0]  cfg_block_shift;
    bit                  block_mapped [DEF_MAX_BLOCKS];
    int                  slot_of_block [DEF_MAX_BLOCKS];
    int                  slots_used;
    bit                  dense_reached;
    logic [WORD_W-1:0]   tangent_words [DEF_MAX_VERTICES];
    logic [WORD_W-1:0]   bitangent_words [DEF_MAX_VERTICES];
    logic [WORD_W-1:0]   normal_words [DEF_MAX_VERTICES];

    out_item_t           rsp_expected [$];
    int                  touched_vertices [$];
    int                  mismatch_count = 0;
    bit                  steady = 1'b0;
    bit                  hold_active = 1'b0;
    event                rsp_hold_ev;

    sparse_block_detail_store u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int eff_shift_now();
        if (cfg_block_shift < SHIFT_MIN)
            return int'(SHIFT_MIN);
        if (cfg_block_shift > SHIFT_MAX)
            return int'(SHIFT_MAX);
        return int'(cfg_block_shift);
    endfunction

    function automatic int eff_total_now();
        int total;
        total = int'(cfg_vertex_total);
        if (total > DEF_MAX_VERTICES)
            total = DEF_MAX_VERTICES;
        if (total > (DEF_MAX_BLOCKS << eff_shift_now()))
            total = DEF_MAX_BLOCKS << eff_shift_now();
        return total;
    endfunction

    task automatic clear_model();
        for (int i = 0; i < DEF_MAX_BLOCKS; i++)
        begin
            block_mapped[i]  = 1'b0;
            slot_of_block[i] = 0;
        end
        for (int i = 0; i < DEF_MAX_VERTICES; i++)
        begin
            tangent_words[i]   = '0;
            bitangent_words[i] = '0;
            normal_words[i]    = '0;
        end
        slots_used    = 0;
        dense_reached = 1'b0;
        touched_vertices.delete();
    endtask

    // Updates the table for one request and returns its response.
    function automatic out_item_t predict_response(input in_item_t it);
        out_item_t r;
        int        sh;
        int        total;
        int        nblocks;
        int        vtx;
        int        blk;
        int        idx;
        bit        all_zero;
        sh       = eff_shift_now();
        total    = eff_total_now();
        nblocks  = (total + (1 << sh) - 1) >> sh;
        vtx      = int'(it.vertex);
        all_zero = (it.tangent_bits == '0) && (it.bitangent_bits == '0) &&
                   (it.normal_bits == '0);
        r = '0;
        if (vtx < total)
        begin
            r.in_range = 1'b1;
            blk = vtx >> sh;
            if (blk < DEF_MAX_BLOCKS)
            begin
                if (it.req_type == REQ_WRITE)
                begin
                    if (!block_mapped[blk] && all_zero)
                        r.write_dropped = 1'b1;
                    else
                    begin
                        if (!block_mapped[blk])
                        begin
                            block_mapped[blk]  = 1'b1;
                            slot_of_block[blk] = slots_used;
                            slots_used++;
                            if (slots_used >= nblocks)
                                dense_reached = 1'b1;
                        end
                        idx = (slot_of_block[blk] << sh) + (vtx & ((1 << sh) - 1));
                        if (idx < DEF_MAX_VERTICES)
                        begin
                            tangent_words[idx]   = it.tangent_bits;
                            bitangent_words[idx] = it.bitangent_bits;
                            normal_words[idx]    = it.normal_bits;
                        end
                    end
                end
                else if (block_mapped[blk])
                begin
                    idx = (slot_of_block[blk] << sh) + (vtx & ((1 << sh) - 1));
                    if (idx < DEF_MAX_VERTICES)
                    begin
                        r.read_tangent   = tangent_words[idx];
                        r.read_bitangent = bitangent_words[idx];
                        r.read_normal    = normal_words[idx];
                    end
                end
                r.block_present = block_mapped[blk];
            end
            else if (it.req_type == REQ_WRITE)
                r.write_dropped = 1'b1;
        end
        else if (it.req_type == REQ_WRITE)
            r.write_dropped = 1'b1;
        r.dense_mode    = dense_reached;
        r.stored_blocks = slots_used[COUNT_W-1:0];
        return r;
    endfunction

    // Sender: random gaps unless steady, then hold the payload until the transfer.
    task automatic send_req(input in_item_t it);
        out_item_t want;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= it;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        want = predict_response(it);
        rsp_expected.insert(rsp_expected.size(), want);
    endtask

    task automatic send_fields(input logic rtype, input int vtx, input logic [31:0] t,
                               input logic [31:0] b, input logic [31:0] n);
        in_item_t it;
        it.req_type       = rtype;
        it.vertex         = vtx[VERTEX_W-1:0];
        it.tangent_bits   = t;
        it.bitangent_bits = b;
        it.normal_bits    = n;
        send_req(it);
    endtask

    task automatic wait_drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (rsp_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_VERTEX_TOTAL)
            cfg_vertex_total = value[VTOTAL_W-1:0];
        else
            cfg_block_shift = value[SHIFT_W-1:0];
        clear_model();
        @(posedge clk);
    endtask

    task automatic configure(input logic [PDATA_W-1:0] vtotal, input logic [PDATA_W-1:0] shift);
        wait_drain();
        write_reg(REG_VERTEX_TOTAL, vtotal);
        write_reg(REG_BLOCK_SHIFT, shift);
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return '0;
        if (pick < 25)
            return '1;
        return $urandom;
    endfunction

    // Mostly in-range writes and reads of written vertices, some noise.
    function automatic in_item_t make_item();
        in_item_t it;
        int       total;
        int       pick;
        int       vtx;
        total = eff_total_now();
        pick  = $urandom_range(99);
        if (total == 0 || $urandom_range(99) < 5)
            vtx = $urandom_range(DEF_MAX_VERTICES - 1);
        else if (total < DEF_MAX_VERTICES && $urandom_range(99) < 5)
            vtx = $urandom_range(DEF_MAX_VERTICES - 1, total);
        else
            vtx = $urandom_range(total - 1);
        it.tangent_bits   = rand_word();
        it.bitangent_bits = rand_word();
        it.normal_bits    = rand_word();
        if (pick < 8)
        begin
            it.req_type       = 1'($urandom_range(1));
            vtx               = $urandom_range(DEF_MAX_VERTICES - 1);
            it.tangent_bits   = $urandom;
            it.bitangent_bits = $urandom;
            it.normal_bits    = $urandom;
        end
        else if (pick < 18)
        begin
            it.req_type       = REQ_WRITE;
            it.tangent_bits   = '0;
            it.bitangent_bits = '0;
            it.normal_bits    = '0;
        end
        else if (pick < 55)
            it.req_type = REQ_WRITE;
        else
        begin
            it.req_type = REQ_READ;
            if (touched_vertices.size() != 0 && $urandom_range(99) < 60)
                vtx = touched_vertices[$urandom_range(touched_vertices.size() - 1)];
        end
        if (it.req_type == REQ_WRITE)
        begin
            touched_vertices.insert(touched_vertices.size(), vtx);
            if (touched_vertices.size() > POOL_DEPTH)
                void'(touched_vertices.pop_front());
        end
        it.vertex = vtx[VERTEX_W-1:0];
        return it;
    endfunction

    // After reset the field is empty: every vertex out of range
    task automatic test_empty_field();
        send_fields(REQ_READ, 0, '0, '0, '0);
        send_fields(REQ_WRITE, 0, 32'h1234_5678, '1, 32'h1);
        send_fields(REQ_READ, DEF_MAX_VERTICES - 1, '0, '0, '0);
    endtask

    task automatic test_basic_access();
        configure(DEF_MAX_VERTICES, 32'(SHIFT_MIN));
        send_fields(REQ_READ, 0, '0, '0, '0);
        send_fields(REQ_WRITE, 0, '0, '0, '0);
        send_fields(REQ_WRITE, 0, '1, '1, '1);
        send_fields(REQ_READ, 0, '0, '0, '0);
        send_fields(REQ_WRITE, DEF_MAX_VERTICES - 1, 32'hAAAA_AAAA, 32'h5555_5555, 32'h1);
        send_fields(REQ_READ, DEF_MAX_VERTICES - 1, '1, '1, '1);
        // zero write into a block that already has a slot is stored
        send_fields(REQ_WRITE, 1, '0, '0, '0);
        send_fields(REQ_READ, 1, '0, '0, '0);
        send_fields(REQ_READ, 2, '0, '0, '0);
        send_fields(REQ_READ, 4, '0, '0, '0);
        send_fields(REQ_WRITE, 3, '0, '0, 32'h8000_0000);
        send_fields(REQ_READ, 3, '0, '0, '0);
    endtask

    task automatic test_config_limits();
        // total above capacity and shift above the maximum: one block covers all
        configure(32'h0000_1FFF, 32'h0000_000F);
        send_fields(REQ_WRITE, DEF_MAX_VERTICES - 1, 32'hDEAD_BEEF, '0, '0);
        send_fields(REQ_READ, 0, '0, '0, '0);
        send_fields(REQ_READ, DEF_MAX_VERTICES - 1, '0, '0, '0);
        // upper data bits ignored; shift below minimum acts as the minimum
        configure(32'hFFFF_E005, 32'hFFFF_FFF0);
        send_fields(REQ_WRITE, 4, 32'h1, 32'h2, 32'h3);
        send_fields(REQ_WRITE, 0, 32'h4, '0, '0);
        send_fields(REQ_WRITE, 5, 32'h5, 32'h6, 32'h7);
        send_fields(REQ_READ, 4, '0, '0, '0);
        configure(DEF_MAX_VERTICES + 1, 32'(SHIFT_MAX));
        send_fields(REQ_WRITE, 100, '0, '1, '0);
        send_fields(REQ_READ, 100, '0, '0, '0);
    endtask

    task automatic test_streaming();
        configure(200, 3);
        steady = 1'b1;
        repeat (150) send_req(make_item());
        steady = 1'b0;
    endtask

    task automatic test_backpressure();
        configure(DEF_MAX_VERTICES, 4);
        steady = 1'b1;
        -> rsp_hold_ev;
        repeat (60) send_req(make_item());
        steady = 1'b0;
        repeat (20) send_req(make_item());
        // sender waits for every outstanding response
        wait_drain();
        repeat (20) send_req(make_item());
    endtask

    task automatic test_random_mix();
        int vtotal;
        int shift;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    vtotal = DEF_MAX_VERTICES;
                    shift  = 6;
                end
                1:
                begin
                    vtotal = 37;
                    shift  = 0;
                end
                2:
                begin
                    vtotal = 8191;
                    shift  = 13;
                end
                default:
                begin
                    vtotal = $urandom_range(8191);
                    shift  = $urandom_range(15);
                    if ($urandom_range(1) == 0)
                        vtotal = $urandom_range(300, 1);
                end
            endcase
            configure(vtotal, shift);
            repeat (160) send_req(make_item());
        end
    endtask

    // Receiver: random stalls, or a long hold requested by a test.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (hold_active)
            rsp_stall <= 1'b1;
        else
            rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    initial
    begin
        forever
        begin
            @(rsp_hold_ev);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active = 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (rsp_expected.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected response: expected none, actual %h", $time, rsp_data);
            end
            else
            begin
                want = rsp_expected.pop_front();
                check_field("read_tangent", want.read_tangent, rsp_data.read_tangent);
                check_field("read_bitangent", want.read_bitangent, rsp_data.read_bitangent);
                check_field("read_normal", want.read_normal, rsp_data.read_normal);
                check_field("in_range", 32'(want.in_range), 32'(rsp_data.in_range));
                check_field("block_present", 32'(want.block_present),
                            32'(rsp_data.block_present));
                check_field("write_dropped", 32'(want.write_dropped),
                            32'(rsp_data.write_dropped));
                check_field("dense_mode", 32'(want.dense_mode), 32'(rsp_data.dense_mode));
                check_field("stored_blocks", 32'(want.stored_blocks),
                            32'(rsp_data.stored_blocks));
            end
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        req_valid = 1'b0;
        req_data  = '0;
        cfg_vertex_total = '0;
        cfg_block_shift  = SHIFT_RESET;
        clear_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_field();
        test_basic_access();
        test_config_limits();
        test_streaming();
        test_backpressure();
        test_random_mix();
        wait_drain();

        if (mismatch_count == 0 && rsp_expected.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
